FILE: hw/rtl/huffman_code_bit_packer_macros.svh
// Assertion helpers, clocked on clk, off during rst.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// ante implies cons in the same cycle
`define HCBP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int EFF_LEN      = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int ACC_W        = CODE_W + 7;
  localparam int CNT_W        = 5;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  localparam logic [SYM_W-1:0] END_SYMBOL_RESET = 8'd36;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  typedef struct packed {
    logic              fin;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } hcbp_entry_t;

  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/hcbp_front.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hcbp_pkg::SYM_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [hcbp_pkg::SYM_W-1:0] in_symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] in_code,
  input  logic [hcbp_pkg::LEN_W-1:0] in_len,
  output logic                      push,
  output hcbp_pkg::hcbp_entry_t     push_entry,
  input  logic                      fifo_full
);
  import hcbp_pkg::*;

  logic [CODE_W+LEN_W-1:0] code_mem [256];
  logic [255:0]            code_vld;
  logic [SYM_W-1:0]        end_symbol;
  logic [CODE_W+LEN_W-1:0] rd_data;
  logic                    rd_vld;
  logic                    s1_valid;
  logic                    s1_fin;
  logic                    accept;
  logic                    is_load;
  logic                    is_lookup;
  logic [SYM_W-1:0]        rd_addr;
  logic [LEN_W-1:0]        len_sat;
  logic [LEN_W-1:0]        s1_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || !fifo_full;
  assign accept    = in_valid && in_ready;
  assign push      = s1_valid && !fifo_full;

  always_comb begin
    is_load   = 1'b0;
    is_lookup = 1'b0;
    unique case (in_action)
      ACT_LOAD:               is_load   = 1'b1;
      ACT_ENCODE, ACT_FINISH: is_lookup = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr = (in_action == ACT_FINISH) ? end_symbol : in_symbol;
  assign len_sat = (in_len > LEN_W'(EFF_LEN)) ? LEN_W'(EFF_LEN) : in_len;
  assign s1_len  = rd_vld ? rd_data[CODE_W +: LEN_W] : '0;

  assign push_entry.fin  = s1_fin;
  assign push_entry.len  = s1_len;
  assign push_entry.code = rd_data[CODE_W-1:0] & code_mask(s1_len);

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      code_mem[in_symbol] <= {len_sat, in_code};
    end
    if (accept) begin
      rd_data <= code_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_vld   <= '0;
      end_symbol <= END_SYMBOL_RESET;
      s1_valid   <= 1'b0;
      s1_fin     <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        end_symbol <= cfg_data;
      end
      if (accept && is_load) begin
        code_vld[in_symbol] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= is_lookup;
        s1_fin   <= (in_action == ACT_FINISH);
        rd_vld   <= code_vld[rd_addr];
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  `HCBP_ASSERT_NEXT(a_s1_hold, s1_valid && !push, s1_valid && $stable(push_entry),
    "stalled lookup changed")
  `HCBP_ASSERT(a_no_accept_stall, s1_valid && fifo_full, !accept,
    "beat taken over stalled lookup")

endmodule

FILE: hw/rtl/hcbp_fifo.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hcbp_pkg::hcbp_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output hcbp_pkg::hcbp_entry_t pop_entry,
  output logic                  not_empty
);
  import hcbp_pkg::*;

  hcbp_entry_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  `HCBP_ASSERT(a_count_max, 1'b1, count <= (FIFO_AW+1)'(FIFO_DEPTH), "queue overflow")

endmodule

FILE: hw/rtl/hcbp_back.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  hcbp_pkg::hcbp_entry_t pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import hcbp_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             fin;
  logic             out_free;
  logic             emit;
  logic             is_last;
  logic [ACC_W-1:0] acc_e;
  logic [CNT_W-1:0] cnt_e;
  logic             fin_e;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt_next;
  logic             fin_next;

  assign out_free = !out_valid || out_ready;
  assign emit     = (cnt >= CNT_W'(8) || fin) && out_free;
  assign is_last  = fin && (cnt < CNT_W'(8));

  always_comb begin
    acc_e = acc;
    cnt_e = cnt;
    fin_e = fin;
    if (emit && is_last) begin
      acc_e = '0;
      cnt_e = '0;
      fin_e = 1'b0;
    end else if (emit) begin
      acc_e = acc >> 8;
      cnt_e = cnt - CNT_W'(8);
    end
  end

  assign pop = not_empty && !fin_e && (cnt_e < CNT_W'(8));

  always_comb begin
    acc_next = acc_e;
    cnt_next = cnt_e;
    fin_next = fin_e;
    if (pop) begin
      acc_next = acc_e | (ACC_W'(pop_entry.code) << cnt_e[2:0]);
      cnt_next = cnt_e + CNT_W'(pop_entry.len);
      fin_next = pop_entry.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      out_byte  <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
      fin <= fin_next;
      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= acc[7:0];
        out_last  <= is_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HCBP_ASSERT(a_cnt_range, 1'b1, cnt <= CNT_W'(ACC_W), "accumulator count overrun")
  `HCBP_ASSERT_NEXT(a_last_clears, emit && is_last && !pop, cnt == '0 && !fin && out_last,
    "finish did not clear accumulator")

endmodule

FILE: hw/rtl/huffman_code_bit_packer.sv
// Channel   Dir  Signals                         Beat contents
// s_axis    in   tvalid tready tdata[31:0] tuser  symbol, code_bits, code_length; action
// m_axis    out  tvalid tready tdata[7:0] tlast   out_byte; last
// cfg       in   valid ready data[7:0]            end_symbol
//
// Lookup reads the table RAM into a register; a queue of four entries feeds the packer.
// Input beats are taken every cycle while the queue has room.
// The packer emits one byte per cycle while m_axis is ready; the output port is the limit.
// Reset is synchronous; it clears the code table valid bits, the queue and the accumulator.
// A stall on m_axis backs up through the queue to s_axis; cfg is always ready.
module huffman_code_bit_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // symbol[7:0], code_bits[23:8], code_length[28:24]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import hcbp_pkg::*;

  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  hcbp_entry_t push_entry;
  hcbp_entry_t pop_entry;

  hcbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .in_symbol  (s_axis_tdata[7:0]),
    .in_code    (s_axis_tdata[23:8]),
    .in_len     (s_axis_tdata[28:24]),
    .push       (push),
    .push_entry (push_entry),
    .fifo_full  (full)
  );

  hcbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (not_empty)
  );

  hcbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
